// ----- sv/tgc_pkg.sv -----
package tgc_pkg;
  localparam int RawBits = 12;
  localparam int CoordBits = 11;
  localparam int SwipeMin = 20;
  localparam int TapMinMs = 50;
  localparam int StepDivs = 40;
  localparam int Recip5 = 52429;
  localparam int Recip5Shift = 18;

  localparam logic [2:0] DirNear = 3'd0;
  localparam logic [2:0] DirLeft = 3'd1;
  localparam logic [2:0] DirRight = 3'd2;
  localparam logic [2:0] DirUp = 3'd3;
  localparam logic [2:0] DirDown = 3'd4;
  localparam logic [2:0] DirIdle = 3'd5;

  localparam logic [1:0] ReqNone = 2'd0;
  localparam logic [1:0] ReqVolume = 2'd1;
  localparam logic [1:0] ReqStations = 2'd2;
  localparam logic [1:0] ReqPlayer = 2'd3;

  localparam logic [1:0] ModePlayer = 2'd0;
  localparam logic [1:0] ModeVolume = 2'd1;
  localparam logic [1:0] ModeStations = 2'd2;

  localparam logic [2:0] BtnNone = 3'd0;
  localparam logic [2:0] BtnCenter = 3'd1;
  localparam logic [2:0] BtnLeft = 3'd2;
  localparam logic [2:0] BtnRight = 3'd3;
  localparam logic [2:0] BtnVolDown = 3'd4;
  localparam logic [2:0] BtnVolUp = 3'd5;

  localparam logic [2:0] RegXMin = 3'd0;
  localparam logic [2:0] RegXMax = 3'd1;
  localparam logic [2:0] RegYMin = 3'd2;
  localparam logic [2:0] RegYMax = 3'd3;
  localparam logic [2:0] RegWidth = 3'd4;
  localparam logic [2:0] RegHeight = 3'd5;
  localparam logic [2:0] RegLong = 3'd6;
  localparam logic [2:0] RegRegion = 3'd7;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic update;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
  } stat_t;
endpackage

// ----- sv/tgc_if.sv -----
interface tgc_in_if #(parameter int RawBits = 12);
  logic valid;
  logic ready;
  logic touched;
  logic [RawBits-1:0] raw_x;
  logic [RawBits-1:0] raw_y;
  logic [31:0] now_ms;
  logic [1:0] screen_mode;
  modport source(output valid, touched, raw_x, raw_y, now_ms, screen_mode, input ready);
  modport sink(input valid, touched, raw_x, raw_y, now_ms, screen_mode, output ready);
endinterface

interface tgc_out_if #(parameter int CoordBits = 11);
  logic valid;
  logic ready;
  logic [1:0] mode_request;
  logic step_event;
  logic step_forward;
  logic [2:0] button_event;
  logic [2:0] swipe_direction;
  logic [CoordBits-1:0] mapped_x;
  logic [CoordBits-1:0] mapped_y;
  modport source(output valid, mode_request, step_event, step_forward, button_event,
                 swipe_direction, mapped_x, mapped_y, input ready);
  modport sink(input valid, mode_request, step_event, step_forward, button_event,
               swipe_direction, mapped_x, mapped_y, output ready);
endinterface

// ----- sv/tgc_div.sv -----
module tgc_div #(
  parameter int NumBits = 23,
  parameter int DenBits = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] q_q, q_d;
  logic [DenBits:0] r_q, r_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DenBits:0] sh;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh = {r_q[DenBits-1:0], q_q[NumBits-1]};
    if (start_i) begin
      q_d = num_i;
      r_d = '0;
      den_d = den_i;
      cnt_d = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q};
        q_d = {q_q[NumBits-2:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

// ----- sv/tgc_datapath.sv -----
module tgc_datapath #(
  parameter int RawBits = tgc_pkg::RawBits,
  parameter int CoordBits = tgc_pkg::CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tgc_pkg::ctrl_t       ctrl_i,
  output tgc_pkg::stat_t       stat_o,
  input  logic                 touched_i,
  input  logic [RawBits-1:0]   raw_x_i,
  input  logic [RawBits-1:0]   raw_y_i,
  input  logic [31:0]          now_ms_i,
  input  logic [1:0]           screen_mode_i,
  input  logic [RawBits-1:0]   x_min_i,
  input  logic [RawBits-1:0]   x_max_i,
  input  logic [RawBits-1:0]   y_min_i,
  input  logic [RawBits-1:0]   y_max_i,
  input  logic [CoordBits-1:0] width_i,
  input  logic [CoordBits-1:0] height_i,
  input  logic [15:0]          long_ms_i,
  input  logic                 region_on_i,
  output logic [1:0]           req_o,
  output logic                 step_o,
  output logic                 fwd_o,
  output logic [2:0]           btn_o,
  output logic [2:0]           dir_o,
  output logic [CoordBits-1:0] mx_o,
  output logic [CoordBits-1:0] my_o
);
  localparam int NumBits = RawBits + CoordBits;
  localparam int DB = CoordBits + 1;
  localparam int MW = CoordBits + 18;

  logic touched_q;
  logic [RawBits-1:0] rx_q, ry_q;
  logic [31:0] now_q;
  logic [1:0] mode_q;
  logic was_q;
  logic [CoordBits-1:0] sx_q, sy_q, ax_q, ay_q, mx_q, my_q;
  logic [2:0] dir_q;
  logic [31:0] ps_q;
  logic [1:0] req_q;
  logic step_q, fwd_q;
  logic [2:0] btn_q;

  logic [RawBits-1:0] lo, hi, raw;
  logic [CoordBits-1:0] size;
  logic [NumBits-1:0] num, quot;
  logic div_done;
  logic [CoordBits-1:0] clamp;
  logic zero_map;

  assign lo = ctrl_i.div_sel_y ? y_min_i : x_min_i;
  assign hi = ctrl_i.div_sel_y ? y_max_i : x_max_i;
  assign raw = ctrl_i.div_sel_y ? ry_q : rx_q;
  assign size = ctrl_i.div_sel_y ? height_i : width_i;
  assign num = NumBits'(raw - lo) * NumBits'(size);
  assign zero_map = (hi <= lo) || (size == '0) || (raw <= lo);

  tgc_div #(.NumBits(NumBits), .DenBits(RawBits)) u_div (
    .clk_i, .rst_ni,
    .start_i(ctrl_i.div_start),
    .num_i(num),
    .den_i(hi - lo),
    .done_o(div_done),
    .quot_o(quot)
  );
  assign stat_o.div_done = div_done;

  always_comb begin
    if (zero_map) clamp = '0;
    else if (quot > NumBits'(size - 1'b1)) clamp = size - 1'b1;
    else clamp = quot[CoordBits-1:0];
  end

  logic [DB-1:0] dx, dy, adx, ady;
  logic nx, ny;
  logic [2:0] cls;
  always_comb begin
    dx = {1'b0, mx_q} - {1'b0, sx_q};
    dy = {1'b0, my_q} - {1'b0, sy_q};
    nx = mx_q < sx_q;
    ny = my_q < sy_q;
    adx = nx ? {1'b0, sx_q - mx_q} : dx;
    ady = ny ? {1'b0, sy_q - my_q} : dy;
    if (adx > DB'(tgc_pkg::SwipeMin) || ady > DB'(tgc_pkg::SwipeMin)) begin
      if (adx > ady) cls = (!nx && adx != '0) ? tgc_pkg::DirRight : tgc_pkg::DirLeft;
      else cls = (!ny && ady != '0) ? tgc_pkg::DirDown : tgc_pkg::DirUp;
    end else begin
      cls = tgc_pkg::DirNear;
    end
  end

  // step test: d*40 >= 2*size
  logic [CoordBits-1:0] vd, sd;
  logic vstep, sstep;
  assign vd = (mx_q > ax_q) ? mx_q - ax_q : ax_q - mx_q;
  assign sd = (my_q > ay_q) ? my_q - ay_q : ay_q - my_q;
  assign vstep = (width_i != '0) &&
                 ((CoordBits+6)'(vd) * (CoordBits+6)'(tgc_pkg::StepDivs) >=
                  (CoordBits+6)'({width_i, 1'b0}));
  assign sstep = (height_i != '0) &&
                 ((CoordBits+6)'(sd) * (CoordBits+6)'(tgc_pkg::StepDivs) >=
                  (CoordBits+6)'({height_i, 1'b0}));

  // divide by 5 through the reciprocal, exact below 2^18
  logic [MW-1:0] wl_p, wh_p, hl_p, hh_p;
  logic [CoordBits-1:0] wl, wh, hl, hh;
  assign wl_p = MW'(width_i) * MW'(tgc_pkg::Recip5);
  assign wh_p = MW'({width_i, 2'b00}) * MW'(tgc_pkg::Recip5);
  assign hl_p = MW'(height_i) * MW'(tgc_pkg::Recip5);
  assign hh_p = MW'({height_i, 2'b00}) * MW'(tgc_pkg::Recip5);
  assign wl = wl_p[tgc_pkg::Recip5Shift +: CoordBits];
  assign wh = wh_p[tgc_pkg::Recip5Shift +: CoordBits];
  assign hl = hl_p[tgc_pkg::Recip5Shift +: CoordBits];
  assign hh = hh_p[tgc_pkg::Recip5Shift +: CoordBits];

  logic [2:0] tap;
  always_comb begin
    if (!region_on_i) tap = tgc_pkg::BtnCenter;
    else if (sx_q < wl && sy_q < hl) tap = tgc_pkg::BtnLeft;
    else if (sx_q < wl && sy_q > hh) tap = tgc_pkg::BtnVolDown;
    else if (sx_q > wh && sy_q < hl) tap = tgc_pkg::BtnRight;
    else if (sx_q > wh && sy_q > hh) tap = tgc_pkg::BtnVolUp;
    else if (sx_q > wl && sx_q < wh && sy_q > hl && sy_q < hh) tap = tgc_pkg::BtnCenter;
    else tap = tgc_pkg::BtnNone;
  end

  logic [31:0] held;
  assign held = now_q - ps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_q <= 1'b1;
      sx_q <= '0;
      sy_q <= '0;
      ax_q <= '0;
      ay_q <= '0;
      dir_q <= tgc_pkg::DirIdle;
      ps_q <= '0;
    end else if (ctrl_i.update) begin
      was_q <= touched_q;
      if (touched_q) begin
        if (!was_q) begin
          sx_q <= mx_q;
          sy_q <= my_q;
          ax_q <= mx_q;
          ay_q <= my_q;
          dir_q <= tgc_pkg::DirNear;
          ps_q <= now_q;
        end else begin
          dir_q <= cls;
          if (cls == tgc_pkg::DirLeft || cls == tgc_pkg::DirRight) begin
            ps_q <= now_q;
            if ((mode_q == tgc_pkg::ModePlayer || mode_q == tgc_pkg::ModeVolume) && vstep)
              ax_q <= mx_q;
          end else if (cls == tgc_pkg::DirUp || cls == tgc_pkg::DirDown) begin
            ps_q <= now_q;
            if ((mode_q == tgc_pkg::ModePlayer || mode_q == tgc_pkg::ModeStations) && sstep)
              ay_q <= my_q;
          end
        end
      end else if (was_q) begin
        dir_q <= tgc_pkg::DirIdle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      touched_q <= touched_i;
      rx_q <= raw_x_i;
      ry_q <= raw_y_i;
      now_q <= now_ms_i;
      mode_q <= screen_mode_i;
      mx_q <= '0;
      my_q <= '0;
    end
    if (ctrl_i.cap_x) mx_q <= clamp;
    if (ctrl_i.cap_y) my_q <= clamp;
    if (ctrl_i.update) begin
      req_q <= tgc_pkg::ReqNone;
      step_q <= 1'b0;
      fwd_q <= 1'b0;
      btn_q <= tgc_pkg::BtnNone;
      if (touched_q && was_q) begin
        if (cls == tgc_pkg::DirLeft || cls == tgc_pkg::DirRight) begin
          if (mode_q == tgc_pkg::ModePlayer || mode_q == tgc_pkg::ModeVolume) begin
            req_q <= tgc_pkg::ReqVolume;
            step_q <= vstep;
            fwd_q <= vstep && (mx_q > ax_q);
          end
        end else if (cls == tgc_pkg::DirUp || cls == tgc_pkg::DirDown) begin
          if (mode_q == tgc_pkg::ModePlayer || mode_q == tgc_pkg::ModeStations) begin
            req_q <= tgc_pkg::ReqStations;
            step_q <= sstep;
            fwd_q <= sstep && (my_q > ay_q);
          end
        end
      end else if (!touched_q && was_q && dir_q == tgc_pkg::DirNear) begin
        if (held < {16'd0, long_ms_i}) begin
          if (held > 32'(tgc_pkg::TapMinMs)) btn_q <= tap;
        end else begin
          req_q <= (mode_q == tgc_pkg::ModePlayer) ? tgc_pkg::ReqStations
                                                   : tgc_pkg::ReqPlayer;
        end
      end
    end
  end

  assign req_o = req_q;
  assign step_o = step_q;
  assign fwd_o = fwd_q;
  assign btn_o = btn_q;
  assign dir_o = dir_q;
  assign mx_o = mx_q;
  assign my_o = my_q;
endmodule

// ----- sv/tgc_ctrl.sv -----
module tgc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_touched_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tgc_pkg::ctrl_t ctrl_o,
  input  tgc_pkg::stat_t stat_i
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDivX = 3'd1;
  localparam logic [2:0] SWaitX = 3'd2;
  localparam logic [2:0] SDivY = 3'd3;
  localparam logic [2:0] SWaitY = 3'd4;
  localparam logic [2:0] SUpd = 3'd5;
  localparam logic [2:0] SOut = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = in_touched_i ? SDivX : SUpd;
        end
      end
      SDivX: begin
        ctrl_o.div_start = 1'b1;
        state_d = SWaitX;
      end
      SWaitX: begin
        if (stat_i.div_done) begin
          ctrl_o.cap_x = 1'b1;
          state_d = SDivY;
        end
      end
      SDivY: begin
        ctrl_o.div_sel_y = 1'b1;
        ctrl_o.div_start = 1'b1;
        state_d = SWaitY;
      end
      SWaitY: begin
        ctrl_o.div_sel_y = 1'b1;
        if (stat_i.div_done) begin
          ctrl_o.cap_y = 1'b1;
          state_d = SUpd;
        end
      end
      SUpd: begin
        ctrl_o.update = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        out_valid_o = 1'b1;
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          state_d = SIdle;
          if (in_valid_i) begin
            ctrl_o.load = 1'b1;
            state_d = in_touched_i ? SDivX : SUpd;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ----- sv/touch_gesture_classifier.sv -----
// A touched sample runs two 23-step divisions, X then Y, on one shared divider; a release skips them.
// The block takes no new sample until the result has left; the next is taken on the cycle the result leaves.
// The serial restoring divider sets the rate, one quotient bit per cycle.
// Reset (rst_ni low, asynchronous) restores the default calibration and gesture state.
module touch_gesture_classifier #(
  parameter int RawBits = tgc_pkg::RawBits,
  parameter int CoordBits = tgc_pkg::CoordBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tgc_in_if.sink      in_if,
  tgc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [RawBits-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic [CoordBits-1:0] w_q, h_q;
  logic [15:0] long_q;
  logic reg_q;
  logic [2:0] idx;
  tgc_pkg::ctrl_t ctrl;
  tgc_pkg::stat_t stat;

  assign pready = 1'b1;
  assign idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= RawBits'(400);
      xmax_q <= RawBits'(3800);
      ymin_q <= RawBits'(260);
      ymax_q <= RawBits'(3800);
      w_q <= CoordBits'(320);
      h_q <= CoordBits'(240);
      long_q <= 16'd1000;
      reg_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        tgc_pkg::RegXMin: xmin_q <= pwdata[RawBits-1:0];
        tgc_pkg::RegXMax: xmax_q <= pwdata[RawBits-1:0];
        tgc_pkg::RegYMin: ymin_q <= pwdata[RawBits-1:0];
        tgc_pkg::RegYMax: ymax_q <= pwdata[RawBits-1:0];
        tgc_pkg::RegWidth: w_q <= pwdata[CoordBits-1:0];
        tgc_pkg::RegHeight: h_q <= pwdata[CoordBits-1:0];
        tgc_pkg::RegLong: long_q <= pwdata[15:0];
        tgc_pkg::RegRegion: reg_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tgc_pkg::RegXMin: prdata = 32'(xmin_q);
      tgc_pkg::RegXMax: prdata = 32'(xmax_q);
      tgc_pkg::RegYMin: prdata = 32'(ymin_q);
      tgc_pkg::RegYMax: prdata = 32'(ymax_q);
      tgc_pkg::RegWidth: prdata = 32'(w_q);
      tgc_pkg::RegHeight: prdata = 32'(h_q);
      tgc_pkg::RegLong: prdata = 32'(long_q);
      tgc_pkg::RegRegion: prdata = 32'(reg_q);
      default: prdata = '0;
    endcase
  end

  tgc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid),
    .in_touched_i(in_if.touched),
    .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .ctrl_o(ctrl),
    .stat_i(stat)
  );

  tgc_datapath #(.RawBits(RawBits), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl),
    .stat_o(stat),
    .touched_i(in_if.touched),
    .raw_x_i(in_if.raw_x),
    .raw_y_i(in_if.raw_y),
    .now_ms_i(in_if.now_ms),
    .screen_mode_i(in_if.screen_mode),
    .x_min_i(xmin_q),
    .x_max_i(xmax_q),
    .y_min_i(ymin_q),
    .y_max_i(ymax_q),
    .width_i(w_q),
    .height_i(h_q),
    .long_ms_i(long_q),
    .region_on_i(reg_q),
    .req_o(out_if.mode_request),
    .step_o(out_if.step_event),
    .fwd_o(out_if.step_forward),
    .btn_o(out_if.button_event),
    .dir_o(out_if.swipe_direction),
    .mx_o(out_if.mapped_x),
    .my_o(out_if.mapped_y)
  );
endmodule
